// ===== rtl/rsam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsam_pkg
// shared types and constants for the rotated sorted array minimum unit
// ----------------------------------------------------------------------------
package rsam_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [6:0] {
        ST_LOAD = 7'b0000001,
        ST_RLO  = 7'b0000010,
        ST_RHI  = 7'b0000100,
        ST_WHI  = 7'b0001000,
        ST_CHK  = 7'b0010000,
        ST_WMID = 7'b0100000,
        ST_SCAN = 7'b1000000
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/rsam_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsam_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module rsam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/rotated_sorted_array_minimum_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_sorted_array_minimum_unit
// minimum of a rotated ascending array by binary search over an element ram
// ----------------------------------------------------------------------------
// Elements are taken one per cycle (start high while busy is low) and written
// to a ram of MAX_ELEMENTS entries; elements past a full store are dropped.
// An element with i_last_element set closes the array and starts the search,
// and busy stays high until the result is out. All reads go through the one
// registered read port of the ram: setup reads the low and then the high
// element, each halving step reads the midpoint, and when the midpoint,
// low and high values are all equal a linear scan reads from low to high.
// The result appears on o_minimum_value for exactly one cycle with o_valid
// high and cannot be held off by the receiver; busy is already low in that
// cycle, and the fill count is cleared for the next array.
// ----------------------------------------------------------------------------
module rotated_sorted_array_minimum_unit #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [rsam_pkg::DATA_W-1:0] i_element_value,
    input  wire logic                            i_last_element,
    output logic                                 o_valid,
    output logic signed [rsam_pkg::DATA_W-1:0]   o_minimum_value
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ELEMENTS);

    rsam_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [IW-1:0]    r_low, n_low;
    logic [IW-1:0]    r_high, n_high;
    logic [IW:0]      r_idx, n_idx;
    logic             r_svld, n_svld;
    logic signed [rsam_pkg::DATA_W-1:0] r_low_val, n_low_val;
    logic signed [rsam_pkg::DATA_W-1:0] r_high_val, n_high_val;
    logic signed [rsam_pkg::DATA_W-1:0] r_mid_val, n_mid_val;
    logic signed [rsam_pkg::DATA_W-1:0] r_scan, n_scan;
    logic             r_valid, n_valid;
    logic signed [rsam_pkg::DATA_W-1:0] r_min, n_min;

    logic                               accept;
    logic                               wr_en;
    logic [IW-1:0]                      rd_addr;
    logic signed [rsam_pkg::DATA_W-1:0] rd_data;
    logic [CW-1:0]                      count;
    logic [IW:0]                        mid_sum;
    logic [IW-1:0]                      mid;
    logic [IW-1:0]                      diff;

    assign busy    = (r_state != rsam_pkg::ST_LOAD);
    assign accept  = start && !busy;
    assign wr_en   = accept && (r_fill < FULL);
    assign count   = wr_en ? r_fill + CW'(1) : r_fill;
    assign mid_sum = {1'b0, r_low} + {1'b0, r_high};
    assign mid     = mid_sum[IW:1];
    assign diff    = r_high - r_low;

    rsam_ram #(
        .WIDTH(rsam_pkg::DATA_W),
        .DEPTH(MAX_ELEMENTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_fill[IW-1:0]),
        .i_wdata(i_element_value),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_low      = r_low;
        n_high     = r_high;
        n_idx      = r_idx;
        n_svld     = 1'b0;
        n_low_val  = r_low_val;
        n_high_val = r_high_val;
        n_mid_val  = r_mid_val;
        n_scan     = r_scan;
        n_valid    = 1'b0;
        n_min      = r_min;
        rd_addr    = r_high;
        case (r_state)
            rsam_pkg::ST_LOAD: begin
                if (accept) begin
                    n_fill = count;
                    if (i_last_element) begin
                        n_low   = '0;
                        n_high  = IW'(count - CW'(1));
                        n_state = rsam_pkg::ST_RLO;
                    end
                end
            end
            rsam_pkg::ST_RLO: begin
                rd_addr = '0;
                n_state = rsam_pkg::ST_RHI;
            end
            rsam_pkg::ST_RHI: begin
                n_low_val = rd_data;
                n_mid_val = rd_data;
                n_state   = rsam_pkg::ST_WHI;
            end
            rsam_pkg::ST_WHI: begin
                n_high_val = rd_data;
                n_state    = rsam_pkg::ST_CHK;
            end
            rsam_pkg::ST_CHK: begin
                rd_addr = mid;
                if (r_low_val < r_high_val) begin
                    n_valid = 1'b1;
                    n_min   = r_mid_val;
                    n_fill  = '0;
                    n_state = rsam_pkg::ST_LOAD;
                end else if (diff == IW'(1)) begin
                    n_valid = 1'b1;
                    n_min   = r_high_val;
                    n_fill  = '0;
                    n_state = rsam_pkg::ST_LOAD;
                end else begin
                    n_idx   = {1'b0, mid};
                    n_state = rsam_pkg::ST_WMID;
                end
            end
            rsam_pkg::ST_WMID: begin
                n_mid_val = rd_data;
                if (rd_data == r_low_val && r_low_val == r_high_val) begin
                    n_scan  = r_low_val;
                    n_idx   = {1'b0, r_low} + (IW + 1)'(1);
                    n_state = rsam_pkg::ST_SCAN;
                end else if (rd_data >= r_low_val) begin
                    n_low     = r_idx[IW-1:0];
                    n_low_val = rd_data;
                    n_state   = rsam_pkg::ST_CHK;
                end else begin
                    n_high     = r_idx[IW-1:0];
                    n_high_val = rd_data;
                    n_state    = rsam_pkg::ST_CHK;
                end
            end
            rsam_pkg::ST_SCAN: begin
                rd_addr = r_idx[IW-1:0];
                if (r_svld && rd_data < r_scan) begin
                    n_scan = rd_data;
                end
                if (r_idx > {1'b0, r_high}) begin
                    n_valid = 1'b1;
                    n_min   = (r_svld && rd_data < r_scan) ? rd_data : r_scan;
                    n_fill  = '0;
                    n_state = rsam_pkg::ST_LOAD;
                end else begin
                    n_idx  = r_idx + (IW + 1)'(1);
                    n_svld = 1'b1;
                end
            end
            default: begin
                n_state = rsam_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsam_pkg::ST_LOAD;
            r_fill  <= '0;
            r_svld  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_svld  <= n_svld;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low      <= n_low;
        r_high     <= n_high;
        r_idx      <= n_idx;
        r_low_val  <= n_low_val;
        r_high_val <= n_high_val;
        r_mid_val  <= n_mid_val;
        r_scan     <= n_scan;
        r_min      <= n_min;
    end

    assign o_valid         = r_valid;
    assign o_minimum_value = r_min;

endmodule
`default_nettype wire

// ===== rtl/rsam_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsam_chk
// port level checks for the rotated sorted array minimum unit
// ----------------------------------------------------------------------------
module rsam_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_last_element,
    input wire logic o_valid
);

    // a result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a result comes only at the end of a search
    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result without a finished search");

    // an element without the last flag keeps the unit ready
    a_load_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_element) |=> (!busy && !o_valid))
        else $error("busy after a plain element transfer");

    // the last element starts the search
    a_last_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_element) |=> busy)
        else $error("search not started after last element");

endmodule

bind rotated_sorted_array_minimum_unit rsam_chk u_rsam_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_last_element(i_last_element),
    .o_valid       (o_valid)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the rotated sorted array minimum unit. It sends a short table
// of directed arrays first: single elements, extreme values, an unrotated
// run, a rotated run, all-equal values and duplicates that force the linear
// scan. Random arrays follow. Most are rotated ascending runs with random
// content and mostly small sizes, some are unsorted noise, and one overflows
// the element store. Each minimum that comes out is checked against a local
// model of the search, or against the value typed into the table.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STORE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int DIRECTED_ROWS = 23;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 64;

    typedef enum int {
        VAL_FULL,
        VAL_NARROW,
        VAL_EXTREME,
        VAL_CONST
    } t_value_mode;

    typedef struct packed {
        logic signed [rsam_pkg::DATA_W-1:0] value;
        logic                               last;
        logic                               typed;
        logic signed [rsam_pkg::DATA_W-1:0] minimum;
    } t_stim_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic signed [rsam_pkg::DATA_W-1:0] i_element_value = '0;
    logic                               i_last_element = 1'b0;
    wire                                busy;
    wire                                o_valid;
    wire signed [rsam_pkg::DATA_W-1:0]  o_minimum_value;

    logic signed [rsam_pkg::DATA_W-1:0] element_mem [0:STORE_DEPTH-1];
    int unsigned                        mem_fill = 0;
    logic signed [rsam_pkg::DATA_W-1:0] expected_minimums [$];
    logic signed [rsam_pkg::DATA_W-1:0] array_buf [0:STORE_DEPTH+1];
    t_stim_row                          directed_rows [0:DIRECTED_ROWS-1];
    logic signed [rsam_pkg::DATA_W-1:0] want_min;

    int mismatch_count  = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int arrays_sent     = 0;
    int idle_pct        = 0;

    rotated_sorted_array_minimum_unit #(
        .MAX_ELEMENTS(STORE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_element_value(i_element_value),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .o_minimum_value(o_minimum_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [rsam_pkg::DATA_W-1:0] search_rotated_min(
            int unsigned n);
        int unsigned                        lo;
        int unsigned                        hi;
        int unsigned                        mid;
        int unsigned                        i;
        logic signed [rsam_pkg::DATA_W-1:0] run_min;
        lo  = 0;
        hi  = n - 1;
        mid = 0;
        while (element_mem[lo] >= element_mem[hi]) begin
            if (hi - lo == 1) begin
                return element_mem[hi];
            end
            mid = (lo + hi) / 2;
            if (element_mem[mid] == element_mem[lo] &&
                element_mem[lo] == element_mem[hi]) begin
                run_min = element_mem[lo];
                for (i = lo; i <= hi; i++) begin
                    if (element_mem[i] < run_min) begin
                        run_min = element_mem[i];
                    end
                end
                return run_min;
            end
            if (element_mem[mid] >= element_mem[lo]) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return element_mem[mid];
    endfunction

    function automatic logic signed [rsam_pkg::DATA_W-1:0] pick_value(
            t_value_mode mode, logic signed [rsam_pkg::DATA_W-1:0] fixed);
        case (mode)
            VAL_FULL: begin
                return $urandom;
            end
            VAL_NARROW: begin
                return $signed($urandom_range(6)) - 3;
            end
            VAL_EXTREME: begin
                case ($urandom_range(4))
                    0: return 32'sh8000_0000;
                    1: return -32'sd1;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    default: return 32'sh7fff_ffff;
                endcase
            end
            default: begin
                return fixed;
            end
        endcase
    endfunction

    task automatic send_item(input logic signed [rsam_pkg::DATA_W-1:0] value,
                             input logic last, input logic typed,
                             input logic signed [rsam_pkg::DATA_W-1:0] typed_min);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_element_value <= value;
        i_last_element  <= last;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (mem_fill < STORE_DEPTH) begin
            element_mem[mem_fill] = value;
            mem_fill++;
        end
        if (last) begin
            expected_minimums.push_back(typed ? typed_min : search_rotated_min(mem_fill));
            mem_fill = 0;
            arrays_sent++;
        end
    endtask

    task automatic send_array(input int n, input logic sorted, input t_value_mode mode);
        int                                 i;
        int                                 j;
        int                                 k;
        logic signed [rsam_pkg::DATA_W-1:0] key;
        logic signed [rsam_pkg::DATA_W-1:0] fixed;
        fixed = $urandom;
        for (i = 0; i < n; i++) begin
            array_buf[i] = pick_value(mode, fixed);
        end
        k = 0;
        if (sorted) begin
            for (i = 1; i < n; i++) begin
                key = array_buf[i];
                j = i - 1;
                while (j >= 0 && array_buf[j] > key) begin
                    array_buf[j + 1] = array_buf[j];
                    j--;
                end
                array_buf[j + 1] = key;
            end
            k = $urandom_range(n - 1);
        end
        for (i = 0; i < n; i++) begin
            send_item(array_buf[(i + k) % n], i == n - 1, 1'b0, '0);
        end
    endtask

    // scoreboard: every strobe is compared with the oldest pending minimum, or counted as a mismatch if none is pending
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_minimums.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected minimum %0d with nothing pending", o_minimum_value);
                end
            end else begin
                want_min = expected_minimums.pop_front();
                results_checked++;
                if (o_minimum_value !== want_min) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("minimum mismatch: expected %0d, got %0d",
                                 want_min, o_minimum_value);
                    end
                end
            end
        end
    end

    initial begin
        int r;
        int n;
        int wait_cycles;
        int full_done;
        t_value_mode mode;

        directed_rows[0]  = '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000};
        directed_rows[1]  = '{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff};
        directed_rows[2]  = '{32'sd0,         1'b1, 1'b1, 32'sd0};
        // unrotated ascending run over the extremes
        directed_rows[3]  = '{32'sh8000_0000, 1'b0, 1'b0, 32'sd0};
        directed_rows[4]  = '{-32'sd1,        1'b0, 1'b0, 32'sd0};
        directed_rows[5]  = '{32'sd0,         1'b0, 1'b0, 32'sd0};
        directed_rows[6]  = '{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh8000_0000};
        directed_rows[7]  = '{32'sd5,         1'b0, 1'b0, 32'sd0};
        directed_rows[8]  = '{32'sd9,         1'b0, 1'b0, 32'sd0};
        directed_rows[9]  = '{-32'sd3,        1'b0, 1'b0, 32'sd0};
        directed_rows[10] = '{32'sd0,         1'b1, 1'b0, 32'sd0};
        // all equal, linear scan
        directed_rows[11] = '{32'sd7,         1'b0, 1'b0, 32'sd0};
        directed_rows[12] = '{32'sd7,         1'b0, 1'b0, 32'sd0};
        directed_rows[13] = '{32'sd7,         1'b0, 1'b0, 32'sd0};
        directed_rows[14] = '{32'sd7,         1'b0, 1'b0, 32'sd0};
        directed_rows[15] = '{32'sd7,         1'b1, 1'b1, 32'sd7};
        // duplicates hiding the dip
        directed_rows[16] = '{32'sd2,         1'b0, 1'b0, 32'sd0};
        directed_rows[17] = '{32'sd2,         1'b0, 1'b0, 32'sd0};
        directed_rows[18] = '{32'sd2,         1'b0, 1'b0, 32'sd0};
        directed_rows[19] = '{32'sd0,         1'b0, 1'b0, 32'sd0};
        directed_rows[20] = '{32'sd2,         1'b1, 1'b0, 32'sd0};
        directed_rows[21] = '{32'sh7fff_ffff, 1'b0, 1'b0, 32'sd0};
        directed_rows[22] = '{32'sh8000_0000, 1'b1, 1'b0, 32'sd0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            send_item(directed_rows[row].value, directed_rows[row].last,
                      directed_rows[row].typed, directed_rows[row].minimum);
        end

        full_done = 0;
        while (items_sent < RANDOM_ITEMS + DIRECTED_ROWS) begin
            case ((arrays_sent / 20) % 4)
                0: idle_pct = 0;
                1: idle_pct = 69;
                2: idle_pct = 0;
                default: idle_pct = 16;
            endcase
            r = $urandom_range(99);
            if (r < 45) begin
                mode = VAL_FULL;
            end else if (r < 75) begin
                mode = VAL_NARROW;
            end else if (r < 90) begin
                mode = VAL_EXTREME;
            end else begin
                mode = VAL_CONST;
            end
            if (full_done == 0 && items_sent >= 800) begin
                // overflow: the tail, last element included, is dropped
                full_done = 1;
                send_array(STORE_DEPTH + 2, 1'b1, mode);
            end else begin
                r = $urandom_range(99);
                if (r < 80) begin
                    n = $urandom_range(8, 1);
                end else if (r < 95) begin
                    n = $urandom_range(40, 9);
                end else begin
                    n = $urandom_range(128, 41);
                end
                send_array(n, $urandom_range(99) >= 15, mode);
            end
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (expected_minimums.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (expected_minimums.size() != 0) begin
            $display("timeout with %0d minimums outstanding", expected_minimums.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            $display("sent %0d elements in %0d arrays, one of them overflowing the store",
                     items_sent, arrays_sent);
            $display("checked %0d minimums, %0d mismatches", results_checked, mismatch_count);
            if (mismatch_count == 0) begin
                $display("Test completed successfully");
            end else begin
                $display("Test completed with failures");
            end
            $finish;
        end
    end

    initial begin
        #10_000_000;
        $display("watchdog expired");
        $display("Test completed with failures");
        $finish;
    end

endmodule
